/* design/idle_framed_rx_segment_ring_core_assert.svh */
// Assertion macros for the idle-framed receive segment ring.
// Included by the top level; expects clk and rst_n in scope.
`ifndef IDLE_FRAMED_RX_SEGMENT_RING_CORE_ASSERT_SVH
`define IDLE_FRAMED_RX_SEGMENT_RING_CORE_ASSERT_SVH

// same-cycle implication
`define IRSR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IRSR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/irsr_pkg.sv */
// Shared types and constants for the idle-framed receive segment ring.
// No dependencies.
package irsr_pkg;

    localparam int BUF_BYTES      = 1024;
    localparam int SEG_MAX        = 255;
    localparam int DESC_SLOTS_DEF = 16;

    localparam int ADDR_W = 10;
    localparam int LEN_W  = 9;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;

    // highest base that still leaves room for a full segment
    localparam int BASE_LIMIT = BUF_BYTES - (SEG_MAX + 1);

    localparam logic [KIND_W-1:0] KIND_RX   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IDLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] rx_byte;
        logic [ADDR_W-1:0] read_address;
    } in_item_t;

    typedef struct packed {
        logic              segment_valid;
        logic [ADDR_W-1:0] segment_start;
        logic [LEN_W-1:0]  segment_length;
        logic [BYTE_W-1:0] read_data;
        logic              byte_dropped;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        logic              is_rx;
        logic              is_idle;
        logic              is_pop;
        logic              is_read;
        logic [BYTE_W-1:0] rx_byte;
        logic [ADDR_W-1:0] read_address;
    } cmd_t;

    // back-end status seen by the top level
    typedef struct packed {
        logic              rd_wait;
        logic [LEN_W-1:0]  open_fill;
        logic [ADDR_W-1:0] segment_base;
    } bk_stat_t;

endpackage

/* design/idle_framed_rx_segment_ring_core.sv */
// Channel | handshake            | payload
// in      | in_valid / in_ready   | in_item  (kind, rx_byte, read_address)
// out     | out_valid / out_ready | out_item (segment_valid .. byte_dropped)
//
// Received-byte and line-idle items finish in the execute state of the back
// end; pop and read items go on to the read-wait state, set by the registered
// read port of the data store and ring. A two-entry queue sits between front
// and back; a result left waiting in the result register stalls the back end
// unless it is taken in the same cycle, while the queue keeps accepting items.
// Reset clears flags, pointers and fill only; stores need no clearing pass.
// Top level of the idle-framed receive segment ring.
// Depends on irsr_pkg, irsr_front, irsr_back and the assertion macro header.
module idle_framed_rx_segment_ring_core #(
    parameter int DESC_SLOTS = irsr_pkg::DESC_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  irsr_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output irsr_pkg::out_item_t out_item
);
    import irsr_pkg::*;

    logic     q_valid;
    logic     q_ready;
    cmd_t     q_cmd;
    bk_stat_t stat;

    irsr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    irsr_back #(
        .DESC_SLOTS (DESC_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .stat      (stat)
    );

`include "idle_framed_rx_segment_ring_core_assert.svh"

    `IRSR_ASSERT_IMP(a_fill_cap, 1'b1, stat.open_fill <= LEN_W'(SEG_MAX + 1), "fill over cap")
    `IRSR_ASSERT_IMP(a_base_room, 1'b1, stat.segment_base <= ADDR_W'(BASE_LIMIT), "base no room")
    `IRSR_ASSERT_IMP(a_rdwait_out, stat.rd_wait, !out_valid && !q_ready, "busy result reg")
    `IRSR_ASSERT_NXT(a_rdwait_done, stat.rd_wait, out_valid && !stat.rd_wait, "read not done")

endmodule

/* design/irsr_front.sv */
// Front end: accepts items, decodes kind into a command, holds a two-entry queue.
// Depends on irsr_pkg.
module irsr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  irsr_pkg::in_item_t in_item,
    output logic               q_valid,
    input  logic               q_ready,
    output irsr_pkg::cmd_t     q_cmd
);
    import irsr_pkg::*;

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       dec_cmd;
    logic       push;
    logic       pop;

    always_comb
    begin
        dec_cmd              = '0;
        dec_cmd.rx_byte      = in_item.rx_byte;
        dec_cmd.read_address = in_item.read_address;
        unique case (in_item.kind)
            KIND_RX:   dec_cmd.is_rx   = 1'b1;
            KIND_IDLE: dec_cmd.is_idle = 1'b1;
            KIND_POP:  dec_cmd.is_pop  = 1'b1;
            KIND_READ: dec_cmd.is_read = 1'b1;
            default:   dec_cmd.is_read = 1'b1;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = ent_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

/* design/irsr_back.sv */
// Back end: data store, descriptor ring, segment pointers and the result register.
// Depends on irsr_pkg.
module irsr_back #(
    parameter int DESC_SLOTS = irsr_pkg::DESC_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  irsr_pkg::cmd_t      q_cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output irsr_pkg::out_item_t out_item,
    output irsr_pkg::bk_stat_t  stat
);
    import irsr_pkg::*;

    localparam int SLOT_W = $clog2(DESC_SLOTS);

    localparam logic ST_EXEC   = 1'b0;
    localparam logic ST_RDWAIT = 1'b1;

    logic              state_reg;
    logic [ADDR_W-1:0] seg_base_reg;
    logic [LEN_W-1:0]  fill_reg;
    logic [SLOT_W-1:0] wslot_reg;
    logic [SLOT_W-1:0] rslot_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;
    out_item_t         out_item_next;
    logic              pend_pop_reg;
    logic              pend_hit_reg;

    logic [BYTE_W-1:0] data_mem [BUF_BYTES];
    logic [ADDR_W-1:0] start_mem [DESC_SLOTS];
    logic [LEN_W-1:0]  len_mem [DESC_SLOTS];
    logic [BYTE_W-1:0] dm_rdata_reg;
    logic [ADDR_W-1:0] st_rdata_reg;
    logic [LEN_W-1:0]  ln_rdata_reg;

    logic              take;
    logic              full;
    logic              ring_busy;
    logic              close_seg;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W:0]   seg_end;
    logic [ADDR_W-1:0] base_next;
    logic              rd_in_range;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        // the ring wraps one short of its depth
        if (s == SLOT_W'(DESC_SLOTS - 2))
        begin
            return '0;
        end
        return s + 1'b1;
    endfunction

    assign q_ready     = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign take        = q_valid && q_ready;
    assign full        = (fill_reg >= LEN_W'(SEG_MAX + 1));
    assign ring_busy   = (wslot_reg != rslot_reg);
    assign close_seg   = take && q_cmd.is_idle && (fill_reg != '0);
    assign waddr       = seg_base_reg + ADDR_W'(fill_reg);
    assign seg_end     = {1'b0, seg_base_reg} + (ADDR_W+1)'(fill_reg);
    assign base_next   = (seg_end <= (ADDR_W+1)'(BASE_LIMIT)) ? seg_end[ADDR_W-1:0] : '0;
    assign rd_in_range = ({1'b0, q_cmd.read_address} < (ADDR_W+1)'(BUF_BYTES));

    // data store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (take && q_cmd.is_rx && !full)
        begin
            data_mem[waddr] <= q_cmd.rx_byte;
        end
        if (take && q_cmd.is_read)
        begin
            dm_rdata_reg <= data_mem[q_cmd.read_address];
        end
    end

    // descriptor ring
    always_ff @(posedge clk)
    begin
        if (close_seg)
        begin
            start_mem[wslot_reg] <= seg_base_reg;
            len_mem[wslot_reg]   <= fill_reg;
        end
        if (take && q_cmd.is_pop)
        begin
            st_rdata_reg <= start_mem[rslot_reg];
            ln_rdata_reg <= len_mem[rslot_reg];
        end
    end

    always_comb
    begin
        out_item_next = out_item_reg;
        if (take && (q_cmd.is_rx || q_cmd.is_idle))
        begin
            out_item_next              = '0;
            out_item_next.byte_dropped = q_cmd.is_rx && full;
        end
        else if (state_reg == ST_RDWAIT)
        begin
            out_item_next = '0;
            if (pend_pop_reg)
            begin
                if (pend_hit_reg)
                begin
                    out_item_next.segment_valid  = 1'b1;
                    out_item_next.segment_start  = st_rdata_reg;
                    out_item_next.segment_length = ln_rdata_reg;
                end
            end
            else if (pend_hit_reg)
            begin
                out_item_next.read_data = dm_rdata_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        if (take)
        begin
            pend_pop_reg <= q_cmd.is_pop;
            pend_hit_reg <= q_cmd.is_pop ? ring_busy : rd_in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_EXEC;
            seg_base_reg  <= '0;
            fill_reg      <= '0;
            wslot_reg     <= '0;
            rslot_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_EXEC:
                begin
                    if (take)
                    begin
                        if (q_cmd.is_pop || q_cmd.is_read)
                        begin
                            state_reg <= ST_RDWAIT;
                            if (out_ready)
                            begin
                                out_valid_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                        end
                        if (q_cmd.is_rx && !full)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        if (close_seg)
                        begin
                            wslot_reg    <= slot_inc(wslot_reg);
                            seg_base_reg <= base_next;
                            fill_reg     <= '0;
                        end
                        if (q_cmd.is_pop && ring_busy)
                        begin
                            rslot_reg <= slot_inc(rslot_reg);
                        end
                    end
                    else if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                ST_RDWAIT:
                begin
                    state_reg     <= ST_EXEC;
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                    state_reg <= ST_EXEC;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_item          = out_item_reg;
    assign stat.rd_wait      = (state_reg == ST_RDWAIT);
    assign stat.open_fill    = fill_reg;
    assign stat.segment_base = seg_base_reg;

endmodule
